### src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Transfer payload structs, byte class bundle, parser phases and status codes.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// Size field geometry
	localparam int SIZE_BITS       = 32;
	localparam int MAX_SIZE_DIGITS = 8;
	localparam int DIGIT_CNT_W     = $clog2(MAX_SIZE_DIGITS + 1);
	localparam int BUDGET_W        = 32;

	// Register reset value
	localparam logic [BUDGET_W-1:0] MAX_BODY_RESET = 32'd1048576;

	// Input transfer codes
	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;

	// Framing characters
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	// Parser phases, one-hot
	typedef enum logic [5:0] {
		PH_SIZE    = 6'b000001,
		PH_SIZE_LF = 6'b000010,
		PH_DATA    = 6'b000100,
		PH_DATA_CR = 6'b001000,
		PH_DATA_LF = 6'b010000,
		PH_DONE    = 6'b100000
	} hcbd_phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} hcbd_in_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        size_done;
		logic [31:0] chunk_length;
		logic        body_done;
		logic [1:0]  status;
	} hcbd_out_t;

	// Classification of one body byte
	typedef struct packed {
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} hcbd_class_t;

endpackage

### src/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder, one byte a cycle
// Input register, framing parser, and result register; output stalls pause it.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall / in_data carry one item per transfer: a body byte or
//   a restart that begins a new body. out_valid / out_stall / out_data give
//   exactly one result per input item, in order.
//   max_body_size_we / max_body_size_wdata write the body budget limit; the
//   new value is loaded into the budget at the next restart.
//   A result is registered: the item is parsed out of the input register
//   straight into the result register. Throughput: one item per cycle while
//   the result is not stalled; the per-byte parse step (hex shift-add, budget
//   compare and subtract, or remaining count decrement) is combinational.
//   Receiver stall: the result register holds its value and the input
//   register keeps its item; in_stall rises only once both are full.
//   Reset: parse state returns to expecting a size line, status is ok, the
//   limit and budget take 1048576, and both pipeline registers are empty.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                max_body_size_we,
	input  logic [31:0]         max_body_size_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcbd_pkg::hcbd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hcbd_pkg::hcbd_out_t out_data
);
	import hcbd_pkg::*;

	logic [31:0]  max_body_q;
	logic         valid_s1;
	hcbd_in_t     item_s1;
	hcbd_class_t  cls;
	hcbd_out_t    result;
	logic         advance;
	logic         step;
	logic         in_xfer;

	// Pipeline control
	assign advance  = !out_valid || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_body_q <= MAX_BODY_RESET;
		else if (max_body_size_we) max_body_q <= max_body_size_wdata;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (advance || !valid_s1) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) item_s1 <= in_data;
	end

	hcbd_classify u_classify (
		.data_byte (item_s1.data_byte),
		.cls       (cls)
	);

	hcbd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.item          (item_s1),
		.cls           (cls),
		.max_body_size (max_body_q),
		.result        (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (advance) out_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step) out_data <= result;
	end

endmodule

### src/hcbd_classify.sv
// ----------------------------------------------------------------------------
// hcbd_classify: body byte classifier
// Decodes a byte into hex digit value and CR / LF flags.
// ----------------------------------------------------------------------------
module hcbd_classify (
	input  logic [7:0]          data_byte,
	output hcbd_pkg::hcbd_class_t cls
);
	import hcbd_pkg::*;

	logic [7:0] lower;

	// Fold upper case letters onto lower case
	assign lower = data_byte | 8'h20;

	always_comb begin
		cls.is_cr   = (data_byte == CHAR_CR);
		cls.is_lf   = (data_byte == CHAR_LF);
		cls.is_hex  = 1'b0;
		cls.hex_val = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = data_byte[3:0];
		end else if (lower >= 8'h61 && lower <= 8'h66) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(lower - 8'h57);
		end
	end

endmodule

### src/hcbd_parser.sv
// ----------------------------------------------------------------------------
// hcbd_parser: chunk framing state and per-byte result logic
// Holds the parse state and computes one result for the item being stepped.
// ----------------------------------------------------------------------------
module hcbd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  hcbd_pkg::hcbd_in_t    item,
	input  hcbd_pkg::hcbd_class_t cls,
	input  logic [31:0]           max_body_size,
	output hcbd_pkg::hcbd_out_t   result
);
	import hcbd_pkg::*;

	hcbd_phase_t            phase_q, phase_d;
	logic [SIZE_BITS-1:0]   size_accum_q, size_accum_d;
	logic [DIGIT_CNT_W-1:0] digit_count_q, digit_count_d;
	logic [SIZE_BITS-1:0]   chunk_rem_q, chunk_rem_d;
	logic [BUDGET_W-1:0]    budget_q, budget_d;
	logic                   last_chunk_q, last_chunk_d;
	logic [1:0]             err_q, err_d;
	logic [SIZE_BITS-1:0]   rem_dec;

	assign rem_dec = (chunk_rem_q != '0) ? chunk_rem_q - SIZE_BITS'(1) : '0;

	// Next state and result
	always_comb begin
		phase_d       = phase_q;
		size_accum_d  = size_accum_q;
		digit_count_d = digit_count_q;
		chunk_rem_d   = chunk_rem_q;
		budget_d      = budget_q;
		last_chunk_d  = last_chunk_q;
		err_d         = err_q;
		result        = '0;

		if (item.func == FUNC_RESTART) begin
			phase_d       = PH_SIZE;
			size_accum_d  = '0;
			digit_count_d = '0;
			chunk_rem_d   = '0;
			budget_d      = max_body_size;
			last_chunk_d  = 1'b0;
			err_d         = ST_OK;
		end else if (err_q == ST_OK) begin
			unique case (phase_q)
				PH_SIZE: begin
					if (cls.is_hex) begin
						if (digit_count_q >= DIGIT_CNT_W'(MAX_SIZE_DIGITS) ||
						    (|size_accum_q[SIZE_BITS-1 -: 4])) begin
							err_d = ST_INVALID;
						end else begin
							size_accum_d  = {size_accum_q[SIZE_BITS-5:0], cls.hex_val};
							digit_count_d = digit_count_q + DIGIT_CNT_W'(1);
						end
					end else if (cls.is_cr && digit_count_q != '0) begin
						phase_d = PH_SIZE_LF;
					end else begin
						err_d = ST_INVALID;
					end
				end
				PH_SIZE_LF: begin
					if (!cls.is_lf) begin
						err_d = ST_INVALID;
					end else if (size_accum_q > budget_q) begin
						err_d = ST_TOO_LARGE;
					end else begin
						budget_d            = budget_q - size_accum_q;
						result.size_done    = 1'b1;
						result.chunk_length = size_accum_q;
						if (size_accum_q == '0) begin
							last_chunk_d = 1'b1;
							phase_d      = PH_DATA_CR;
						end else begin
							chunk_rem_d = size_accum_q;
							phase_d     = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					result.payload_valid = 1'b1;
					result.payload_byte  = item.data_byte;
					chunk_rem_d          = rem_dec;
					if (rem_dec == '0) phase_d = PH_DATA_CR;
				end
				PH_DATA_CR: begin
					if (cls.is_cr) phase_d = PH_DATA_LF;
					else err_d = ST_INVALID;
				end
				PH_DATA_LF: begin
					if (!cls.is_lf) begin
						err_d = ST_INVALID;
					end else if (last_chunk_q) begin
						result.body_done = 1'b1;
						phase_d          = PH_DONE;
					end else begin
						phase_d       = PH_SIZE;
						size_accum_d  = '0;
						digit_count_d = '0;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
		result.status = err_d;
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIZE;
			size_accum_q  <= '0;
			digit_count_q <= '0;
			chunk_rem_q   <= '0;
			budget_q      <= MAX_BODY_RESET;
			last_chunk_q  <= 1'b0;
			err_q         <= ST_OK;
		end else if (step) begin
			phase_q       <= phase_d;
			size_accum_q  <= size_accum_d;
			digit_count_q <= digit_count_d;
			chunk_rem_q   <= chunk_rem_d;
			budget_q      <= budget_d;
			last_chunk_q  <= last_chunk_d;
			err_q         <= err_d;
		end
	end

endmodule

### src/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker: port-level checks for the chunked body decoder
// Watches the result channel and the consistency of result fields.
// ----------------------------------------------------------------------------
module hcbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input hcbd_pkg::hcbd_out_t out_data
);
	import hcbd_pkg::*;

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Payload only while status is ok, never with a size or end marker
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.payload_valid |->
			out_data.status == ST_OK && !out_data.size_done && !out_data.body_done)
		else $error("payload byte with other markers or error");

	// Size acceptance and body end only with ok status, and never together
	a_marker_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.size_done || out_data.body_done) |->
			out_data.status == ST_OK && !(out_data.size_done && out_data.body_done))
		else $error("size or end marker with error status");

	// Only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == ST_OK || out_data.status == ST_INVALID ||
			out_data.status == ST_TOO_LARGE)
		else $error("undefined status code");

	// Input side never stalls while the output side is free
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result register can drain");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
